/* design/qte_pkg.sv */
// qte_pkg: shared widths, constants and the CORDIC arctangent table
// for the quaternion to Euler angle pipeline. No dependencies.
package qte_pkg;
    localparam int QW   = 16;  // quaternion component width
    localparam int VW   = 40;  // CORDIC x/y datapath width
    localparam int AW   = 34;  // angle accumulator width, Q30 radians
    localparam int SW   = 34;  // products and sums, Q28
    localparam int RW   = 58;  // radicand width for the square root
    localparam int CW   = 29;  // square root result width
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [SW-1:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [15:0]   ANG_LIMIT   = 16'sd25736;
    localparam logic signed [15:0]   PITCH_LIMIT = 16'sd12868;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] acc;
    } t_vec;

    function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sh3243F6A8;
                5'd1:  r = 34'sh1DAC6705;
                5'd2:  r = 34'sh0FADBAFC;
                5'd3:  r = 34'sh07F56EA6;
                5'd4:  r = 34'sh03FEAB76;
                5'd5:  r = 34'sh01FFD55B;
                5'd6:  r = 34'sh00FFFAAA;
                5'd7:  r = 34'sh007FFF55;
                5'd8:  r = 34'sh003FFFEA;
                5'd9:  r = 34'sh001FFFFD;
                5'd10: r = 34'sh000FFFFF;
                5'd11: r = 34'sh0007FFFF;
                5'd12: r = 34'sh0003FFFF;
                5'd13: r = 34'sh0001FFFF;
                5'd14: r = 34'sh0000FFFF;
                5'd15: r = 34'sh00007FFF;
                5'd16: r = 34'sh00003FFF;
                5'd17: r = 34'sh00001FFF;
                5'd18: r = 34'sh00000FFF;
                5'd19: r = 34'sh000007FF;
                5'd20: r = 34'sh000003FF;
                5'd21: r = 34'sh000001FF;
                5'd22: r = 34'sh000000FF;
                5'd23: r = 34'sh0000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Q30 angle to saturated Q13, round half up
    function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] a,
                                                 input logic signed [15:0] lim);
        logic signed [AW:0] s;
        logic signed [AW:0] r;
        begin
            s = AW'(a) + (AW+1)'(65536);
            s = {a[AW-1], a} + (AW+1)'(65536);
            r = s >>> 17;
            if (r > (AW+1)'(lim))       return lim;
            else if (r < -(AW+1)'(lim)) return -lim;
            else                        return r[15:0];
        end
    endfunction
endpackage

/* design/qte_sqrt_cell.sv */
// qte_sqrt_cell: one registered restoring square-root cell, two radicand bits per cell.
// Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  logic                       i_clk,
    input  logic [qte_pkg::RW-1:0]     i_rem,
    input  logic [qte_pkg::CW-1:0]     i_root,
    input  logic [qte_pkg::RW-1:0]     i_rad,
    input  logic signed [qte_pkg::SW-1:0] i_s,
    output logic [qte_pkg::RW-1:0]     o_rem,
    output logic [qte_pkg::CW-1:0]     o_root,
    output logic [qte_pkg::RW-1:0]     o_rad,
    output logic signed [qte_pkg::SW-1:0] o_s
);
    localparam int SH = qte_pkg::RW - 2 - 2*STAGE;
    logic [qte_pkg::RW-1:0] n_rem, trial;
    logic [qte_pkg::CW-1:0] n_root;
    logic [qte_pkg::RW-1:0] cur;

    always_comb begin
        cur   = {i_rem[qte_pkg::RW-3:0], i_rad[SH+1 -: 2]};
        trial = {i_root[qte_pkg::CW-2:0], 2'b01} & {qte_pkg::RW{1'b1}};
        if (cur >= trial) begin
            n_rem  = cur - trial;
            n_root = {i_root[qte_pkg::CW-2:0], 1'b1};
        end else begin
            n_rem  = cur;
            n_root = {i_root[qte_pkg::CW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_root <= n_root;
        o_rad  <= i_rad;
        o_s    <= i_s;
    end
endmodule

/* design/qte_cordic_cell.sv */
// qte_cordic_cell: one registered CORDIC vectoring micro-rotation.
// Depends on qte_pkg.
module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  qte_pkg::t_vec      i_v,
    output qte_pkg::t_vec      o_v
);
    qte_pkg::t_vec n_v;
    logic signed [qte_pkg::VW-1:0] xs, ys;

    always_comb begin
        xs = i_v.x >>> STEP;
        ys = i_v.y >>> STEP;
        if (!i_v.y[qte_pkg::VW-1]) begin
            n_v.x   = i_v.x + ys;
            n_v.y   = i_v.y - xs;
            n_v.acc = i_v.acc + qte_pkg::atan_tab(5'(STEP));
        end else begin
            n_v.x   = i_v.x - ys;
            n_v.y   = i_v.y + xs;
            n_v.acc = i_v.acc - qte_pkg::atan_tab(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        o_v <= n_v;
    end
endmodule

/* design/qte_atan2.sv */
// qte_atan2: quadrant pre-rotation followed by a row of CORDIC cells.
// Depends on qte_pkg, qte_cordic_cell.
module qte_atan2 #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic signed [qte_pkg::VW-1:0] i_y,
    input  logic signed [qte_pkg::VW-1:0] i_x,
    output logic signed [qte_pkg::AW-1:0] o_ang
);
    qte_pkg::t_vec v [0:STEPS];
    qte_pkg::t_vec n_pre;
    logic          r_zero [0:STEPS];

    always_comb begin
        n_pre.x = i_x; n_pre.y = i_y; n_pre.acc = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_pre.x = i_y; n_pre.y = -i_x; n_pre.acc = qte_pkg::HALF_PI_Q30;
            end else begin
                n_pre.x = -i_y; n_pre.y = i_x; n_pre.acc = -qte_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        v[0]      <= n_pre;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        qte_cordic_cell #(.STEP(g)) u_cell (.i_clk(i_clk), .i_v(v[g]), .o_v(v[g+1]));
        always_ff @(posedge i_clk) r_zero[g+1] <= r_zero[g];
    end

    assign o_ang = r_zero[STEPS] ? '0 : v[STEPS].acc;
endmodule

/* design/quaternion_to_euler_angles.sv */
// quaternion_to_euler_angles: top level, products, asin argument, square root row,
// three CORDIC rows and output rounding. Depends on qte_pkg, qte_sqrt_cell, qte_atan2.
//
//  channel | ports                                   | handshake
//  input   | i_quat_x/y/z/w                          | i_start & !o_busy
//  result  | o_yaw/pitch/roll_angle, o_pitch_clamped | o_done, one cycle
//
// Fully pipelined: one transaction per cycle, o_busy is always low.
// Registers in order: products, operands, square root row, CORDIC pre-rotation, CORDIC cells, output rounding.
// Reset clears only the valid shift line; the data path carries no reset.
// The receiver cannot stall; results appear once, on o_done.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    input  logic signed [15:0]  i_quat_w,
    output logic                o_done,
    output logic signed [15:0]  o_yaw_angle,
    output logic signed [14:0]  o_pitch_angle,
    output logic signed [15:0]  o_roll_angle,
    output logic                o_pitch_clamped
);
    localparam int SW = qte_pkg::SW;
    localparam int VW = qte_pkg::VW;
    localparam int RW = qte_pkg::RW;
    localparam int CW = qte_pkg::CW;
    localparam int LAT = 2 + CW + 1 + CORDIC_STEPS + 1;

    // stage 1: products
    logic signed [31:0] r_yw, r_xz, r_yy, r_zz, r_xw, r_yz, r_xx, r_xy, r_zw;
    always_ff @(posedge i_clk) begin
        r_yw <= i_quat_y * i_quat_w; r_xz <= i_quat_x * i_quat_z;
        r_yy <= i_quat_y * i_quat_y; r_zz <= i_quat_z * i_quat_z;
        r_xw <= i_quat_x * i_quat_w; r_yz <= i_quat_y * i_quat_z;
        r_xx <= i_quat_x * i_quat_x; r_xy <= i_quat_x * i_quat_y;
        r_zw <= i_quat_z * i_quat_w;
    end

    // stage 2: operands, clamp, radicand
    logic signed [SW-1:0] n_s, n_sc, r_ya, r_yb, r_ra, r_rb, r_s;
    logic [RW-1:0] r_rad;
    logic r_clamp;
    logic signed [2*SW-1:0] n_ss;
    always_comb begin
        n_s  = (SW'(r_xy) + SW'(r_zw)) <<< 1;
        n_sc = n_s;
        if (n_s > qte_pkg::ONE_Q28) n_sc = qte_pkg::ONE_Q28;
        if (n_s < -qte_pkg::ONE_Q28) n_sc = -qte_pkg::ONE_Q28;
        n_ss = n_sc * n_sc;
    end
    always_ff @(posedge i_clk) begin
        r_ya    <= (SW'(r_yw) - SW'(r_xz)) <<< 1;
        r_yb    <= qte_pkg::ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        r_ra    <= (SW'(r_xw) - SW'(r_yz)) <<< 1;
        r_rb    <= qte_pkg::ONE_Q28 - ((SW'(r_xx) + SW'(r_zz)) <<< 1);
        r_s     <= n_sc;
        r_clamp <= (n_s > qte_pkg::ONE_Q28) || (n_s < -qte_pkg::ONE_Q28);
        r_rad   <= (RW'(1) << 56) - RW'(n_ss);
    end

    // square root row, delaying yaw/roll operands alongside
    logic [RW-1:0] rem [0:CW];
    logic [CW-1:0] root [0:CW];
    logic [RW-1:0] rad [0:CW];
    logic signed [SW-1:0] sd [0:CW];
    logic signed [SW-1:0] d_ya [0:CW], d_yb [0:CW], d_ra [0:CW], d_rb [0:CW];
    logic d_cl [0:CW];
    assign rem[0] = '0; assign root[0] = '0; assign rad[0] = r_rad; assign sd[0] = r_s;
    assign d_ya[0] = r_ya; assign d_yb[0] = r_yb; assign d_ra[0] = r_ra;
    assign d_rb[0] = r_rb; assign d_cl[0] = r_clamp;
    for (genvar g = 0; g < CW; g++) begin : g_sq
        qte_sqrt_cell #(.STAGE(g)) u_sq (
            .i_clk(i_clk), .i_rem(rem[g]), .i_root(root[g]), .i_rad(rad[g]), .i_s(sd[g]),
            .o_rem(rem[g+1]), .o_root(root[g+1]), .o_rad(rad[g+1]), .o_s(sd[g+1]));
        always_ff @(posedge i_clk) begin
            d_ya[g+1] <= d_ya[g]; d_yb[g+1] <= d_yb[g];
            d_ra[g+1] <= d_ra[g]; d_rb[g+1] <= d_rb[g];
            d_cl[g+1] <= d_cl[g];
        end
    end

    logic signed [qte_pkg::AW-1:0] a_yaw, a_pitch, a_roll;
    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (.i_clk(i_clk),
        .i_y(VW'(d_ya[CW])), .i_x(VW'(d_yb[CW])), .o_ang(a_yaw));
    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (.i_clk(i_clk),
        .i_y(VW'(d_ra[CW])), .i_x(VW'(d_rb[CW])), .o_ang(a_roll));
    qte_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (.i_clk(i_clk),
        .i_y(VW'(sd[CW])), .i_x(VW'({1'b0, root[CW]})), .o_ang(a_pitch));

    logic r_cl [0:CORDIC_STEPS];
    always_ff @(posedge i_clk) r_cl[0] <= d_cl[CW];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cl
        always_ff @(posedge i_clk) r_cl[g+1] <= r_cl[g];
    end

    logic signed [15:0] n_pitch;
    assign n_pitch = qte_pkg::to_q13(a_pitch, qte_pkg::PITCH_LIMIT);
    always_ff @(posedge i_clk) begin
        o_yaw_angle     <= qte_pkg::to_q13(a_yaw, qte_pkg::ANG_LIMIT);
        o_roll_angle    <= qte_pkg::to_q13(a_roll, qte_pkg::ANG_LIMIT);
        o_pitch_angle   <= n_pitch[14:0];
        o_pitch_clamped <= r_cl[CORDIC_STEPS];
    end

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], i_start};
    end
    assign o_done = r_vld[LAT-1];
    assign o_busy = 1'b0;

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge i_clk) !o_busy) else $error("busy set");
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(LAT) o_done) else $error("done missing");
    a_pitch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pitch_angle <= 15'sd12868 && o_pitch_angle >= -15'sd12868))
        else $error("pitch range");
`endif
endmodule

/* verif/tb.sv */
// tb: self-checking testbench for quaternion_to_euler_angles (yaw, pitch, roll
// via CORDIC). Depends on qte_pkg and the design; has its own angle predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEPS       = qte_pkg::CORDIC_STEPS_DEF;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  STALL_LIMIT = 2000;
    localparam int  N_RANDOM    = 800;
    localparam longint ONE_Q28  = 64'sd1 << 28;
    localparam longint HALF_PI  = 64'sd1686629713;

    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
        64'h00000003, 64'h00000001, 64'h00000000, 64'h00000000
    };

    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
        bit                 wait_empty;   // hold until all angles are back
    } t_quat;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic               clamped;
    } t_euler;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic signed [15:0] i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    logic               o_busy, o_done, o_pitch_clamped;
    logic signed [15:0] o_yaw_angle, o_roll_angle;
    logic signed [14:0] o_pitch_angle;

    t_quat  pending_quats[$];
    t_euler expected_angles[$];
    t_quat  cur_quat;
    bit     failed = 0;
    int     idle_left = 0;
    int     stall_cycles = 0;

    quaternion_to_euler_angles dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint vec_atan2(longint vy, longint vx);
        longint acc, t, xs, ys;
        acc = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            if (vy >= 0) begin
                t = vx; vx = vy; vy = -t; acc = HALF_PI;
            end else begin
                t = vx; vx = -vy; vy = t; acc = -HALF_PI;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx = vx + ys; vy = vy - xs; acc += ATAN_Q30[i];
            end else begin
                vx = vx - ys; vy = vy + xs; acc -= ATAN_Q30[i];
            end
        end
        return acc;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + 65536) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler predict_angles(t_quat q);
        longint x, y, z, w, s, c, yaw_a, roll_a, pitch_a;
        t_euler e;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        e.clamped = 1'b0;
        yaw_a  = vec_atan2(2 * (y * w - x * z), ONE_Q28 - 2 * (y * y + z * z));
        roll_a = vec_atan2(2 * (x * w - y * z), ONE_Q28 - 2 * (x * x + z * z));
        s = 2 * (x * y + z * w);
        if (s > ONE_Q28) begin
            s = ONE_Q28; e.clamped = 1'b1;
        end
        if (s < -ONE_Q28) begin
            s = -ONE_Q28; e.clamped = 1'b1;
        end
        c = int_sqrt((64'd1 << 56) - longint'(s * s));
        pitch_a = vec_atan2(s, c);
        e.yaw   = 16'(round_q13(yaw_a, 25736));
        e.pitch = 15'(round_q13(pitch_a, 12868));
        e.roll  = 16'(round_q13(roll_a, 25736));
        return e;
    endfunction

    task automatic add_quat(int x, int y, int z, int w, bit hold = 0);
        t_quat q;
        q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z); q.qw = 16'(w);
        q.wait_empty = hold;
        pending_quats.push_back(q);
    endtask

    // random direction scaled to unit length, small jitter keeps clamp reachable
    task automatic add_unit_quat();
        real v[4], n;
        n = 0.0;
        for (int k = 0; k < 4; k++) begin
            v[k] = real'(int'($urandom_range(0, 2000)) - 1000);
            n += v[k] * v[k];
        end
        if (n == 0.0) begin
            v[3] = 1.0; n = 1.0;
        end
        n = $sqrt(n);
        add_quat(int'($rtoi(v[0] / n * 16384.0)) + int'($urandom_range(0, 2)) - 1,
                 int'($rtoi(v[1] / n * 16384.0)) + int'($urandom_range(0, 2)) - 1,
                 int'($rtoi(v[2] / n * 16384.0)),
                 int'($rtoi(v[3] / n * 16384.0)));
    endtask

    // driver: accepts on start & !busy, then chooses the next transaction
    always @(posedge i_clk) begin
        bit     drive;
        bit     accepted;
        accepted = i_start && !o_busy && i_rst_n;
        if (accepted) begin
            expected_angles.push_back(predict_angles(cur_quat));
            void'(pending_quats.pop_front());
            if (pending_quats.size() > 100 && $urandom_range(0, 3) == 0)
                idle_left = $urandom_range(1, 4);
        end
        drive = 0;
        if (i_rst_n && pending_quats.size() > 0) begin
            if (idle_left > 0 && !accepted)
                idle_left--;
            if (idle_left == 0 &&
                !(pending_quats[0].wait_empty && expected_angles.size() > 0))
                drive = 1;
        end
        if (drive) begin
            cur_quat = pending_quats[0];
            i_quat_x <= cur_quat.qx;
            i_quat_y <= cur_quat.qy;
            i_quat_z <= cur_quat.qz;
            i_quat_w <= cur_quat.qw;
        end
        i_start <= drive;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_euler e;
        if (i_rst_n && o_done) begin
            stall_cycles = 0;
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected result yaw=%0d pitch=%0d roll=%0d",
                         $time, o_yaw_angle, o_pitch_angle, o_roll_angle);
                failed = 1;
            end else begin
                e = expected_angles.pop_front();
                if (o_yaw_angle !== e.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, o_yaw_angle);
                    failed = 1;
                end
                if (o_pitch_angle !== e.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d",
                             $time, e.pitch, o_pitch_angle);
                    failed = 1;
                end
                if (o_roll_angle !== e.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, e.roll, o_roll_angle);
                    failed = 1;
                end
                if (o_pitch_clamped !== e.clamped) begin
                    $display("%0t: clamp flag expected %0b actual %0b",
                             $time, e.clamped, o_pitch_clamped);
                    failed = 1;
                end
            end
        end else if (i_start && !o_busy && i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog timeout", $time);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        // directed: identity, axes, gimbal lock, clamp, zero operands, extremes
        add_quat(0, 0, 0, 16384);
        add_quat(0, 0, 0, -16384);
        add_quat(16384, 0, 0, 0);
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        add_quat(-16384, 0, 0, 0);
        add_quat(0, -16384, 0, 0);
        add_quat(0, 0, -16384, 0);
        add_quat(11585, 11585, 0, 0);
        add_quat(-11585, 11585, 0, 0);
        add_quat(0, 0, 11586, 11586);
        add_quat(16384, 16384, 0, 0);
        add_quat(-16384, 16384, 0, 0);
        add_quat(0, 8192, 8192, 0);
        add_quat(0, 0, 0, 0);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(8192, 8192, 8192, -8192);
        add_quat(-8192, 8192, -8192, -8192);
        add_quat(0, 11585, 0, -11585, 1);
        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                0, 1: add_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
                2: add_quat(11585 + $urandom_range(0, 8) - 4,
                            11585 + $urandom_range(0, 8) - 4,
                            $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
                default: add_unit_quat();
            endcase
            if (n == N_RANDOM / 2) pending_quats[$].wait_empty = 1;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_quats.size() != 0 || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed && expected_angles.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
design/qte_pkg.sv
design/qte_sqrt_cell.sv
design/qte_cordic_cell.sv
design/qte_atan2.sv
design/quaternion_to_euler_angles.sv
verif/tb.sv
